@@ hw/rtl/rdp_pkg.sv @@
// Package for the replica disk placement block: types, constants, helpers.
// Used by rdp_ctrl, rdp_dp and replica_disk_placement.
package rdp_pkg;

    localparam int MAX_DISKS        = 64;
    localparam int CHUNKS_PER_SUPER = 2;
    localparam int IDX_W            = 6;
    localparam int CNT_W            = 7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FEW_DISKS = 3'd1;
    localparam logic [2:0] ST_BEYOND    = 3'd2;
    localparam logic [2:0] ST_REPEAT    = 3'd3;
    localparam logic [2:0] ST_NOT_BEGUN = 3'd4;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_USABLE = 3'd1;
    localparam logic [2:0] CFG_SSD    = 3'd2;
    localparam logic [2:0] CFG_EXTENT = 3'd3;
    localparam logic [2:0] CFG_ALLOC  = 3'd4;
    localparam logic [2:0] CFG_SEED   = 3'd5;

    localparam logic [2:0] MODE_ONE      = 3'd0;
    localparam logic [2:0] MODE_TWO      = 3'd1;
    localparam logic [2:0] MODE_SSD_ONE  = 3'd2;
    localparam logic [2:0] MODE_SSD_TWO  = 3'd3;
    localparam logic [2:0] MODE_SSD_ONLY = 3'd4;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic        req_type;
        logic [31:0] chunk_num;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] copy_index;
        logic [5:0] slave_index;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_GATHER, S_BCHK, S_SHUF_START, S_DRAW, S_MOD, S_RD, S_RDW,
        S_WR, S_SHUF_NEXT, S_TRIM, S_PLACE, S_PRD, S_PRDW, S_EMIT, S_RESP
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic begin_init;   // latch mode, seed, clear counts
        logic gather;       // one disk index step
        logic sel_ssd;      // operate on the SSD list
        logic shuf_init;    // i = count
        logic draw;         // step LFSR
        logic mod_step;     // one restoring division step
        logic mod_init;
        logic rd_top;       // read list[i-1] and list[j]
        logic wr_swap;      // write swapped pair
        logic shuf_dec;     // i--
        logic trim;
        logic place_init;   // set up copy counter
        logic place_rd;     // read the list at the rotation position
        logic emit;         // load the output register
        logic emit_err;
        logic [2:0] err_code;
        logic place_done;   // advance positions, record chunk
        logic finish_begin;
        logic pos_reset_main;
        logic pos_reset_ssd;
    } t_cmd;

    typedef struct packed {
        logic       gather_done;
        logic       mod_done;
        logic       shuf_done;   // i < 2
        logic       main_few;
        logic       ssd_empty;
        logic       use_ssd;
        logic [1:0] main_k;
        logic       main_wrap;
        logic       ssd_wrap;
        logic       ready;
        logic       beyond;
        logic       repeated;
        logic       copy_last;   // current copy is the last one
        logic       copy_is_ssd;
    } t_sts;

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic [15:0] s;
        s = {1'b0, v[15:1]};
        if (v[0]) s = s ^ LFSR_TAPS;
        return s;
    endfunction

endpackage

@@ hw/rtl/rdp_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module rdp_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

@@ hw/rtl/rdp_dp.sv @@
// Datapath: configuration registers, order lists, LFSR, modulo unit, output register.
// Depends on rdp_pkg and rdp_ram.
module rdp_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  rdp_pkg::t_cfg  i_cfg,
    input  rdp_pkg::t_in   i_item,
    input  logic           i_latch_item,
    input  rdp_pkg::t_cmd  i_cmd,
    output rdp_pkg::t_sts  o_sts,
    output rdp_pkg::t_out  o_result
);
    logic [2:0]  r_mode, r_run_mode;
    logic [63:0] r_usable, r_ssd;
    logic [31:0] r_extent, r_alloc;
    logic [15:0] r_seed, r_lfsr;
    logic [31:0] r_chunk, r_last_chunk;
    logic [rdp_pkg::CNT_W-1:0] r_main_cnt, r_ssd_cnt, r_main_pos, r_ssd_pos;
    logic [rdp_pkg::CNT_W-1:0] r_i, r_disk;
    logic        r_ready;
    // Restoring remainder unit: r_rem = r_num mod r_i, one bit a cycle.
    logic [15:0] r_num;
    logic [rdp_pkg::CNT_W:0] r_rem;
    logic [4:0]  r_mstep;
    logic [rdp_pkg::IDX_W-1:0] r_j;
    logic [1:0]  r_copy;
    rdp_pkg::t_out r_out;

    logic [rdp_pkg::IDX_W-1:0] w_raddr_a, w_raddr_b, w_waddr, w_wdata;
    logic [rdp_pkg::IDX_W-1:0] m_rd_a, m_rd_b, s_rd_a, s_rd_b, w_rd_a, w_rd_b;
    logic w_we_main, w_we_ssd;
    logic [2:0] w_m;
    logic [1:0] w_k;
    logic [rdp_pkg::IDX_W-1:0] w_top;
    logic [rdp_pkg::CNT_W:0] w_trial;
    logic [rdp_pkg::CNT_W-1:0] w_pos_sum, w_pos_mod, w_cnt;
    logic [32:0] w_sc;
    logic [1:0]  w_k_run;
    logic        w_dsk_ok, w_dsk_ssd;

    assign w_m = (r_mode > rdp_pkg::MODE_SSD_ONLY) ? rdp_pkg::MODE_TWO : r_mode;

    function automatic logic [1:0] copies(input logic [2:0] m);
        if (m == rdp_pkg::MODE_ONE || m == rdp_pkg::MODE_SSD_ONE) return 2'd1;
        if (m == rdp_pkg::MODE_SSD_ONLY) return 2'd0;
        return 2'd2;
    endfunction

    assign w_k = copies(w_m);
    assign w_k_run = copies(r_run_mode);
    assign w_top = r_i[rdp_pkg::IDX_W-1:0] - 1'b1;
    assign w_trial = {r_rem[rdp_pkg::CNT_W-1:0], r_num[15]} - {1'b0, r_i};
    assign w_cnt = i_cmd.sel_ssd ? r_ssd_cnt : r_main_cnt;
    assign w_pos_sum = r_main_pos + {5'd0, r_copy - (r_run_mode >= rdp_pkg::MODE_SSD_ONE
                       ? 2'd1 : 2'd0)};
    assign w_pos_mod = (w_pos_sum >= r_main_cnt) ? w_pos_sum - r_main_cnt : w_pos_sum;
    assign w_sc = {1'b0, (r_extent - 32'd1) / rdp_pkg::CHUNKS_PER_SUPER} + 33'd1;
    assign w_dsk_ok = r_usable[r_disk[rdp_pkg::IDX_W-1:0]];
    assign w_dsk_ssd = r_ssd[r_disk[rdp_pkg::IDX_W-1:0]];

    // Address and write selection.
    always_comb begin
        w_raddr_a = w_top;
        w_raddr_b = r_j;
        w_waddr   = w_top;
        w_wdata   = w_rd_b;
        w_we_main = 1'b0;
        w_we_ssd  = 1'b0;
        if (i_cmd.gather) begin
            w_wdata = r_disk[rdp_pkg::IDX_W-1:0];
            if (w_dsk_ok && w_dsk_ssd && r_run_mode >= rdp_pkg::MODE_SSD_ONE) begin
                w_we_ssd = 1'b1;
                w_waddr  = r_ssd_cnt[rdp_pkg::IDX_W-1:0];
            end else if (w_dsk_ok && !w_dsk_ssd && w_k != 2'd0) begin
                w_we_main = 1'b1;
                w_waddr   = r_main_cnt[rdp_pkg::IDX_W-1:0];
            end
        end else if (i_cmd.wr_swap) begin
            w_we_main = !i_cmd.sel_ssd;
            w_we_ssd  = i_cmd.sel_ssd;
        end
        if (i_cmd.place_rd) begin
            w_raddr_a = r_ssd_pos[rdp_pkg::IDX_W-1:0];
            w_raddr_b = w_pos_mod[rdp_pkg::IDX_W-1:0];
        end
    end

    // The swap writes list[top] first (rdata b) then list[j] in the next cycle.
    logic r_swap2;
    logic [rdp_pkg::IDX_W-1:0] r_hold_a;

    rdp_ram #(.WIDTH(rdp_pkg::IDX_W), .DEPTH(rdp_pkg::MAX_DISKS)) u_main (
        .i_clk, .i_we(w_we_main || (r_swap2 && !i_cmd.sel_ssd)),
        .i_waddr(r_swap2 ? r_j : w_waddr), .i_wdata(r_swap2 ? r_hold_a : w_wdata),
        .i_raddr_a(w_raddr_a), .i_raddr_b(w_raddr_b),
        .o_rdata_a(m_rd_a), .o_rdata_b(m_rd_b));

    rdp_ram #(.WIDTH(rdp_pkg::IDX_W), .DEPTH(rdp_pkg::MAX_DISKS)) u_ssd (
        .i_clk, .i_we(w_we_ssd || (r_swap2 && i_cmd.sel_ssd)),
        .i_waddr(r_swap2 ? r_j : w_waddr), .i_wdata(r_swap2 ? r_hold_a : w_wdata),
        .i_raddr_a(w_raddr_a), .i_raddr_b(w_raddr_b),
        .o_rdata_a(s_rd_a), .o_rdata_b(s_rd_b));

    assign w_rd_a = i_cmd.sel_ssd ? s_rd_a : m_rd_a;
    assign w_rd_b = i_cmd.sel_ssd ? s_rd_b : m_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 3'd1; r_usable <= '0; r_ssd <= '0;
            r_extent <= 32'd1; r_alloc <= 32'd1; r_seed <= 16'd1;
            r_run_mode <= 3'd1; r_lfsr <= 16'd1;
            r_main_cnt <= '0; r_ssd_cnt <= '0; r_main_pos <= '0; r_ssd_pos <= '0;
            r_last_chunk <= '1; r_ready <= 1'b0; r_swap2 <= 1'b0;
            r_i <= '0; r_disk <= '0; r_mstep <= '0; r_copy <= '0;
        end else begin
            r_swap2 <= i_cmd.wr_swap;
            if (i_cfg_we) begin
                case (i_cfg.index)
                    rdp_pkg::CFG_MODE:   r_mode   <= i_cfg.data[2:0];
                    rdp_pkg::CFG_USABLE: r_usable <= i_cfg.data;
                    rdp_pkg::CFG_SSD:    r_ssd    <= i_cfg.data;
                    rdp_pkg::CFG_EXTENT: r_extent <= i_cfg.data[31:0];
                    rdp_pkg::CFG_ALLOC:  r_alloc  <= i_cfg.data[31:0];
                    rdp_pkg::CFG_SEED:   r_seed   <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.begin_init) begin
                r_ready <= 1'b0;
                r_run_mode <= w_m;
                r_lfsr <= (r_seed != 16'd0) ? r_seed : 16'd1;
                r_main_cnt <= '0; r_ssd_cnt <= '0; r_disk <= '0;
            end
            if (i_cmd.gather) begin
                r_disk <= r_disk + 1'b1;
                if (w_we_ssd) r_ssd_cnt <= r_ssd_cnt + 1'b1;
                if (w_we_main) r_main_cnt <= r_main_cnt + 1'b1;
            end
            if (i_cmd.shuf_init) r_i <= w_cnt;
            if (i_cmd.draw) r_lfsr <= rdp_pkg::lfsr_next(r_lfsr);
            if (i_cmd.mod_init) begin
                r_num <= r_lfsr; r_rem <= '0; r_mstep <= '0;
            end else if (i_cmd.mod_step) begin
                r_num <= {r_num[14:0], 1'b0};
                r_mstep <= r_mstep + 1'b1;
                if (!w_trial[rdp_pkg::CNT_W]) r_rem <= w_trial;
                else r_rem <= {r_rem[rdp_pkg::CNT_W-1:0], r_num[15]};
                if (r_mstep == 5'd15)
                    r_j <= !w_trial[rdp_pkg::CNT_W] ? w_trial[rdp_pkg::IDX_W-1:0]
                           : {r_rem[rdp_pkg::IDX_W-2:0], r_num[15]};
            end
            if (i_cmd.rd_top) r_hold_a <= w_rd_a;
            if (i_cmd.shuf_dec) r_i <= r_i - 1'b1;
            if (i_cmd.trim && r_extent == r_alloc) begin
                if (w_sc < {26'd0, r_main_cnt}) begin
                    if (w_sc[rdp_pkg::CNT_W-1:0] < {5'd0, w_k})
                        r_main_cnt <= {5'd0, w_k};
                    else
                        r_main_cnt <= w_sc[rdp_pkg::CNT_W-1:0];
                end
            end
            if (i_cmd.pos_reset_main) r_main_pos <= '0;
            if (i_cmd.pos_reset_ssd) r_ssd_pos <= '0;
            if (i_cmd.finish_begin) begin
                r_main_pos <= '0; r_ssd_pos <= '0; r_last_chunk <= '1; r_ready <= 1'b1;
            end
            if (i_cmd.place_init) r_copy <= '0;
            if (i_cmd.emit && !i_cmd.emit_err) r_copy <= r_copy + 1'b1;
            if (i_cmd.place_done) begin
                if (w_k_run != 2'd0) begin
                    r_main_pos <= r_main_pos + 1'b1;
                    r_last_chunk <= r_chunk;
                end
                if (r_run_mode >= rdp_pkg::MODE_SSD_ONE) r_ssd_pos <= r_ssd_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_latch_item) r_chunk <= i_item.chunk_num;
        if (i_cmd.emit) begin
            if (i_cmd.emit_err) begin
                r_out <= '{status: i_cmd.err_code, copy_index: 2'd0, slave_index: '0,
                           last: 1'b1};
            end else begin
                r_out.status <= rdp_pkg::ST_OK;
                r_out.copy_index <= r_copy;
                r_out.slave_index <= o_sts.copy_is_ssd ? s_rd_a : m_rd_b;
                r_out.last <= o_sts.copy_last;
            end
        end
    end

    always_comb begin
        o_sts = '0;
        o_sts.gather_done = (r_disk == 7'(rdp_pkg::MAX_DISKS - 1));
        o_sts.mod_done    = (r_mstep == 5'd16);
        o_sts.shuf_done   = (r_i < 7'd2);
        o_sts.main_few    = (r_main_cnt < {5'd0, w_k_run});
        o_sts.ssd_empty   = (r_ssd_cnt == '0);
        o_sts.use_ssd     = (r_run_mode >= rdp_pkg::MODE_SSD_ONE);
        o_sts.main_k      = w_k_run;
        o_sts.main_wrap   = (r_main_pos >= r_main_cnt);
        o_sts.ssd_wrap    = (r_ssd_pos >= r_ssd_cnt);
        o_sts.ready       = r_ready;
        o_sts.beyond      = (r_chunk >= r_alloc);
        o_sts.repeated    = (r_chunk == r_last_chunk);
        o_sts.copy_is_ssd = o_sts.use_ssd && (r_copy == 2'd0);
        o_sts.copy_last   = ({1'b0, r_copy} + 3'd1 == {1'b0, w_k_run}
                            + (o_sts.use_ssd ? 3'd1 : 3'd0));
    end

    assign o_result = r_out;
endmodule

@@ hw/rtl/rdp_ctrl.sv @@
// Controller state machine for begin and place items.
// Depends on rdp_pkg.
module rdp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  logic           i_out_ready,
    input  rdp_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output logic           o_latch_item,
    output rdp_pkg::t_cmd  o_cmd
);
    rdp_pkg::t_state r_state, n_state;
    logic r_begin, n_begin, r_sel, n_sel, r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdp_pkg::S_IDLE; r_begin <= 1'b0; r_sel <= 1'b0; r_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_begin <= n_begin; r_sel <= n_sel; r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state; n_begin = r_begin; n_sel = r_sel; n_valid = r_valid;
        o_cmd = '0;
        o_cmd.sel_ssd = r_sel;
        o_in_ready = 1'b0;
        o_latch_item = 1'b0;
        if (r_valid && i_out_ready) n_valid = 1'b0;
        case (r_state)
            rdp_pkg::S_IDLE: begin
                o_in_ready = !r_valid;
                if (i_in_valid && !r_valid) begin
                    o_latch_item = 1'b1;
                    n_begin = !i_req_type;
                    if (!i_req_type) begin
                        o_cmd.begin_init = 1'b1;
                        n_state = rdp_pkg::S_GATHER;
                    end else n_state = rdp_pkg::S_DECIDE;
                end
            end
            rdp_pkg::S_GATHER: begin
                o_cmd.gather = 1'b1;
                if (i_sts.gather_done) n_state = rdp_pkg::S_BCHK;
            end
            rdp_pkg::S_BCHK: begin
                if (i_sts.main_k != 2'd0) begin
                    if (i_sts.main_few) begin
                        o_cmd.emit = 1'b1; o_cmd.emit_err = 1'b1;
                        o_cmd.err_code = rdp_pkg::ST_FEW_DISKS;
                        n_state = rdp_pkg::S_RESP;
                    end else begin
                        n_sel = 1'b0; n_state = rdp_pkg::S_SHUF_START;
                    end
                end else if (i_sts.ssd_empty) begin
                    o_cmd.emit = 1'b1; o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = rdp_pkg::ST_FEW_DISKS;
                    n_state = rdp_pkg::S_RESP;
                end else begin
                    n_sel = 1'b1; n_state = rdp_pkg::S_SHUF_START;
                end
            end
            rdp_pkg::S_SHUF_START: begin
                o_cmd.shuf_init = 1'b1;
                n_state = rdp_pkg::S_SHUF_NEXT;
            end
            rdp_pkg::S_SHUF_NEXT: begin
                if (i_sts.shuf_done) n_state = rdp_pkg::S_TRIM;
                else begin
                    o_cmd.draw = 1'b1;
                    n_state = rdp_pkg::S_DRAW;
                end
            end
            rdp_pkg::S_DRAW: begin
                o_cmd.mod_init = 1'b1;
                n_state = rdp_pkg::S_MOD;
            end
            rdp_pkg::S_MOD: begin
                if (i_sts.mod_done) n_state = rdp_pkg::S_RD;
                else o_cmd.mod_step = 1'b1;
            end
            rdp_pkg::S_RD: n_state = rdp_pkg::S_RDW;
            rdp_pkg::S_RDW: begin
                o_cmd.rd_top = 1'b1;
                n_state = rdp_pkg::S_WR;
            end
            rdp_pkg::S_WR: begin
                o_cmd.wr_swap = 1'b1;
                o_cmd.shuf_dec = 1'b1;
                n_state = rdp_pkg::S_SHUF_NEXT;
            end
            rdp_pkg::S_TRIM: begin
                if (r_begin) begin
                    if (!r_sel) begin
                        o_cmd.trim = 1'b1;
                        if (i_sts.use_ssd) begin
                            if (i_sts.ssd_empty) begin
                                o_cmd.emit = 1'b1; o_cmd.emit_err = 1'b1;
                                o_cmd.err_code = rdp_pkg::ST_FEW_DISKS;
                                n_state = rdp_pkg::S_RESP;
                            end else begin
                                n_sel = 1'b1; n_state = rdp_pkg::S_SHUF_START;
                            end
                        end else begin
                            o_cmd.finish_begin = 1'b1; o_cmd.emit = 1'b1;
                            o_cmd.emit_err = 1'b1; o_cmd.err_code = rdp_pkg::ST_OK;
                            n_state = rdp_pkg::S_RESP;
                        end
                    end else begin
                        o_cmd.finish_begin = 1'b1; o_cmd.emit = 1'b1;
                        o_cmd.emit_err = 1'b1; o_cmd.err_code = rdp_pkg::ST_OK;
                        n_state = rdp_pkg::S_RESP;
                    end
                end else begin
                    if (r_sel) o_cmd.pos_reset_ssd = 1'b1;
                    else o_cmd.pos_reset_main = 1'b1;
                    n_state = rdp_pkg::S_PLACE;
                end
            end
            rdp_pkg::S_DECIDE: begin
                if (!i_sts.ready) begin
                    o_cmd.emit = 1'b1; o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = rdp_pkg::ST_NOT_BEGUN;
                    n_state = rdp_pkg::S_RESP;
                end else if (i_sts.main_k != 2'd0 && i_sts.beyond) begin
                    o_cmd.emit = 1'b1; o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = rdp_pkg::ST_BEYOND;
                    n_state = rdp_pkg::S_RESP;
                end else if (i_sts.main_k != 2'd0 && i_sts.repeated) begin
                    o_cmd.emit = 1'b1; o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = rdp_pkg::ST_REPEAT;
                    n_state = rdp_pkg::S_RESP;
                end else n_state = rdp_pkg::S_PLACE;
            end
            rdp_pkg::S_PLACE: begin
                // Reshuffle the main list first, then the SSD list, as needed.
                if (i_sts.main_k != 2'd0 && i_sts.main_wrap) begin
                    n_sel = 1'b0; n_state = rdp_pkg::S_SHUF_START;
                end else if (i_sts.use_ssd && i_sts.ssd_wrap) begin
                    n_sel = 1'b1; n_state = rdp_pkg::S_SHUF_START;
                end else begin
                    o_cmd.place_init = 1'b1;
                    n_state = rdp_pkg::S_PRD;
                end
            end
            rdp_pkg::S_PRD: begin
                o_cmd.place_rd = 1'b1;
                n_state = rdp_pkg::S_PRDW;
            end
            rdp_pkg::S_PRDW: begin
                o_cmd.place_rd = 1'b1;
                if (!r_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_valid = 1'b1;
                    if (i_sts.copy_last) begin
                        o_cmd.place_done = 1'b1;
                        n_state = rdp_pkg::S_IDLE;
                    end else n_state = rdp_pkg::S_PRD;
                end
            end
            rdp_pkg::S_RESP: begin
                n_valid = 1'b1;
                n_state = rdp_pkg::S_IDLE;
            end
            default: n_state = rdp_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_valid;
endmodule

@@ hw/rtl/replica_disk_placement.sv @@
// Top level of the replica disk placement block.
// Depends on rdp_pkg, rdp_ctrl, rdp_dp and rdp_ram.
//
// channel | signals                                  | dir
// in      | i_in_valid, o_in_ready, i_in_data        | in
// out     | o_out_valid, i_out_ready, o_out_data     | out
// cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data     | in
//
// Begin scans all 64 disks, then makes n - 1 shuffle swaps for a list of n;
// each swap waits on a draw through the serial remainder unit.
// A place item first runs a full shuffle of a list when that list wraps.
// Reset is synchronous and active low; no memory clearing pass is needed.
// A stalled output holds the block before the next result is loaded.
module replica_disk_placement (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rdp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rdp_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  rdp_pkg::t_cfg i_cfg_data
);
    rdp_pkg::t_cmd w_cmd;
    rdp_pkg::t_sts w_sts;
    logic w_latch;

    assign o_cfg_ready = 1'b1;

    rdp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .i_req_type(i_in_data.req_type),
        .i_out_ready, .i_sts(w_sts), .o_in_ready, .o_out_valid,
        .o_latch_item(w_latch), .o_cmd(w_cmd));

    rdp_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_we(i_cfg_valid), .i_cfg(i_cfg_data),
        .i_item(i_in_data), .i_latch_item(w_latch), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_result(o_out_data));

    a_no_accept_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken with result pending");
    a_last_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != rdp_pkg::ST_OK) |-> o_out_data.last)
        else $error("error result without last");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.gather, w_cmd.wr_swap, w_cmd.mod_step}))
        else $error("conflicting datapath commands");
endmodule
